[rtl/sha_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 digest block.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenFill = 6'd56;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put;       // append put_byte at the fill position
    logic [7:0] put_byte;
    logic       add_len;   // count eight more message bits
    logic       ld_len;    // write the bit length into words 14 and 15
    logic       start;     // load working variables from the hash
    logic       round;     // run one compression round
    logic       fold;      // add working variables into the hash
    logic       restart;   // back to initial hash, zero length and fill
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } sha_sts_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

[rtl/sha_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, message schedule, round unit, hash and length registers.
// ----------------------------------------------------------------------------
module sha_datapath
  import sha_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sha_cmd_t      cmd_i,
  output sha_sts_t      sts_o,
  output logic [255:0]  hash_o
);

  logic [31:0] buf_q [16];
  logic [31:0] hash_q [8];
  logic [31:0] wv_q [8];
  logic [63:0] len_q;
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;

  logic [31:0] w_new, w_cur, t1, t2, s0, s1, e, a;
  logic [3:0]  widx;
  logic [4:0]  bsh;

  assign widx = fill_q[5:2];
  assign bsh  = 5'd24 - {fill_q[1:0], 3'b000};

  // The buffer doubles as a 16-word schedule window that shifts each round.
  assign s0    = ror(buf_q[1], 7) ^ ror(buf_q[1], 18) ^ (buf_q[1] >> 3);
  assign s1    = ror(buf_q[14], 17) ^ ror(buf_q[14], 19) ^ (buf_q[14] >> 10);
  assign w_new = buf_q[0] + s0 + buf_q[9] + s1;
  assign w_cur = buf_q[0];

  assign e  = wv_q[4];
  assign a  = wv_q[0];
  assign t1 = wv_q[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25))
            + ((e & wv_q[5]) ^ (~e & wv_q[6])) + RoundK[rnd_q] + w_cur;
  assign t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22))
            + ((a & wv_q[1]) ^ (a & wv_q[2]) ^ (wv_q[1] & wv_q[2]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.put) begin
      buf_q[widx] <= (buf_q[widx] & ~(32'hff << bsh)) | ({24'd0, cmd_i.put_byte} << bsh);
    end else if (cmd_i.ld_len) begin
      buf_q[14] <= len_q[63:32];
      buf_q[15] <= len_q[31:0];
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) buf_q[i] <= buf_q[i+1];
      buf_q[15] <= w_new;
    end
    if (cmd_i.start) begin
      for (int i = 0; i < 8; i++) wv_q[i] <= hash_q[i];
    end else if (cmd_i.round) begin
      wv_q[7] <= wv_q[6];
      wv_q[6] <= wv_q[5];
      wv_q[5] <= wv_q[4];
      wv_q[4] <= wv_q[3] + t1;
      wv_q[3] <= wv_q[2];
      wv_q[2] <= wv_q[1];
      wv_q[1] <= wv_q[0];
      wv_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
      len_q  <= '0;
      fill_q <= '0;
      rnd_q  <= '0;
    end else begin
      if (cmd_i.restart) begin
        for (int i = 0; i < 8; i++) hash_q[i] <= InitHash[i];
        len_q  <= '0;
        fill_q <= '0;
      end else begin
        if (cmd_i.fold) begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + wv_q[i];
        end
        if (cmd_i.add_len) len_q <= len_q + 64'd8;
        if (cmd_i.put) fill_q <= fill_q + 6'd1;
      end
      if (cmd_i.start) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
    end
  end

  assign sts_o.fill       = fill_q;
  assign sts_o.last_round = (rnd_q == 6'd63);

  always_comb begin
    for (int i = 0; i < 8; i++) hash_o[255-32*i -: 32] = hash_q[i];
  end

`ifndef SYNTHESIS
  a_round_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.round && !sts_o.last_round |=> rnd_q == $past(rnd_q) + 6'd1)
    else $error("round counter skipped");
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.add_len && !cmd_i.restart |=> len_q == $past(len_q) + 64'd8)
    else $error("bit length step wrong");
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.restart |=> fill_q == 6'd0 && len_q == 64'd0)
    else $error("restart incomplete");
`endif

endmodule

[rtl/sha_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: byte feed, padding, round loop, hash fold and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] in_word_i,
  input  logic [2:0]  in_count_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  part_o,
  input  sha_sts_t    sts_i,
  output sha_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_BYTES, ST_PAD, ST_LEN, ST_ROUND, ST_FOLD, ST_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] word_q;
  logic [2:0]  cnt_q;
  logic [1:0]  bi_q;
  logic        last_q;
  logic        pad_q;   // padding has begun; once the length is loaded, a compression ends with output
  logic        valid_q;
  logic [1:0]  part_q;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = valid_q;
  assign part_o      = part_q;

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_BYTES: begin
        if (cnt_q != 3'd0) begin
          cmd_o.put      = 1'b1;
          cmd_o.add_len  = 1'b1;
          cmd_o.put_byte = word_q[31 - 8*bi_q -: 8];
        end
        if (cnt_q != 3'd0 && sts_i.fill == 6'd63) cmd_o.start = 1'b1;
      end
      ST_PAD: begin
        cmd_o.put      = 1'b1;
        cmd_o.put_byte = pad_q ? 8'h00 : PadByte;
        if (sts_i.fill == 6'd63) cmd_o.start = 1'b1;
      end
      ST_LEN: begin
        cmd_o.ld_len = 1'b1;
        cmd_o.start  = 1'b1;
      end
      ST_ROUND: cmd_o.round = 1'b1;
      ST_FOLD:  cmd_o.fold  = 1'b1;
      ST_OUT: begin
        if (out_ready_i && part_q == 2'd3) cmd_o.restart = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      word_q  <= '0;
      cnt_q   <= '0;
      bi_q    <= '0;
      last_q  <= 1'b0;
      pad_q   <= 1'b0;
      valid_q <= 1'b0;
      part_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            word_q  <= in_word_i;
            cnt_q   <= (in_count_i > 3'd4) ? 3'd4 : in_count_i;
            bi_q    <= '0;
            last_q  <= in_last_i;
            pad_q   <= 1'b0;
            state_q <= ST_BYTES;
          end
        end
        ST_BYTES: begin
          if (cnt_q == 3'd0) begin
            state_q <= last_q ? ST_PAD : ST_IDLE;
          end else begin
            cnt_q <= cnt_q - 3'd1;
            bi_q  <= bi_q + 2'd1;
            if (sts_i.fill == 6'd63) state_q <= ST_ROUND;
          end
        end
        ST_PAD: begin
          pad_q <= 1'b1;
          if (sts_i.fill == 6'd63) state_q <= ST_ROUND;
          else if (sts_i.fill == LenFill - 6'd1) state_q <= ST_LEN;
        end
        ST_LEN: begin
          last_q  <= 1'b0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          if (sts_i.last_round) state_q <= ST_FOLD;
        end
        ST_FOLD: begin
          if (pad_q && !last_q) begin
            state_q <= ST_OUT;
            valid_q <= 1'b1;
            part_q  <= '0;
          end else if (pad_q) begin
            state_q <= ST_PAD;
          end else begin
            state_q <= ST_BYTES;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            part_q <= part_q + 2'd1;
            if (part_q == 2'd3) begin
              valid_q <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !in_ready_o) else $error("input open during output");
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> state_q == ST_OUT) else $error("valid outside output");
  a_restart_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.restart |=> state_q == ST_IDLE) else $error("restart not at end");
`endif

endmodule

[rtl/sha256_message_digest.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_digest
// Streaming SHA-256: message words in, four 64-bit digest words out.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata fields (low bit up)     | tuser / tlast
//  s_axis  | in        | data_word[31:0]               | tuser byte_count, tlast last_word
//  m_axis  | out       | digest_part[63:0]             | tuser part_index, tlast last_part
//
// Each input word is accepted in the idle state, its valid bytes are then written
// one at a time and a closing step ends the word; no new word is taken meanwhile.
// A full 64-byte block then takes 64 rounds and a fold, set by the single round
// unit that runs one round per cycle; the working variables load on the same
// edge that writes the last byte. The last word adds padding, written byte by
// byte, a length load, one or two more compressions, then four output words;
// no input is taken until all four have left. Reset restores the initial hash,
// zero length and empty block.
// ----------------------------------------------------------------------------
module sha256_message_digest
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // data_word[31:0]
  input  logic [2:0]  s_axis_tuser,   // byte_count[2:0]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_part[63:0]
  output logic [1:0]  m_axis_tuser,   // part_index[1:0]
  output logic        m_axis_tlast
);

  sha_cmd_t     cmd;
  sha_sts_t     sts;
  logic [255:0] hash;
  logic [1:0]   part;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_word_i  (s_axis_tdata),
    .in_count_i (s_axis_tuser),
    .in_last_i  (s_axis_tlast),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .part_o     (part),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .hash_o(hash)
  );

  // Part 0 carries the first eight digest bytes.
  assign m_axis_tdata = hash[255 - 64*part -: 64];
  assign m_axis_tuser = part;
  assign m_axis_tlast = (part == 2'd3);

endmodule

[dv/sha256_message_digest_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_digest_tb
// Self-checking bench for the streaming SHA-256 block. Messages of random
// length and content are fed as words with random gaps; a behavioral digest
// predictor computes the four expected output words of every message, and
// each accepted output word is compared field by field against them.
// ----------------------------------------------------------------------------
module sha256_message_digest_tb
  import sha_pkg::*;
;

  localparam int HalfPeriod = 10;
  localparam int ResetCycles = 7;
  localparam int StallLimit = 20000;
  localparam int RandomWords = 107;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [63:0] part;
    logic [1:0]  idx;
    logic        lst;
  } digest_word_t;

  typedef struct {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        lst;
    logic        known;     // expected first digest word typed in below
    logic [63:0] part0;     // first digest word when known
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Predictor state: running hash, gathered block, byte fill and bit length.
  logic [31:0] hash_q [8];
  logic [31:0] blk_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q;

  digest_word_t digest_queue [$];
  logic [63:0]  known_part0 [$];  // first-word checks from the directed table
  int errors = 0;
  int words_sent = 0;
  int digests_seen = 0;
  int idle_cycles = 0;
  bit rx_hold = 1'b0;    // long receiver hold-off in progress
  bit idle_free = 1'b0;  // stretch with no idling on either side

  sha256_message_digest u_top (.*);

  always #(HalfPeriod) clk_i = ~clk_i;

  function automatic logic [31:0] rotr(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk_q[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = hash_q[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_q[i] += v[i];
  endtask

  task automatic append_byte(logic [7:0] b);
    blk_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] = b;
    fill_q++;
    if (fill_q == 0) compress();
  endtask

  task automatic restart_digest();
    for (int i = 0; i < 8; i++) hash_q[i] = InitHash[i];
    fill_q = '0;
    bits_q = '0;
  endtask

  // Feeds one accepted word to the predictor; a last word queues the digest.
  task automatic predict_digest(logic [31:0] data, logic [2:0] cnt, logic lst);
    int n;
    digest_word_t dw;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    for (int i = 0; i < n; i++) begin
      append_byte(data[8*(3-i) +: 8]);
      bits_q += 64'd8;
    end
    if (lst) begin
      append_byte(PadByte);
      while (fill_q != LenFill) append_byte(8'h00);
      blk_q[14] = bits_q[63:32];
      blk_q[15] = bits_q[31:0];
      compress();
      for (int i = 0; i < 4; i++) begin
        dw.part = {hash_q[2*i], hash_q[2*i+1]};
        dw.idx  = 2'(i);
        dw.lst  = (i == 3);
        digest_queue.push_back(dw);
      end
      restart_digest();
    end
  endtask

  function automatic bit idle_now();
    return !idle_free && ($urandom_range(99) < 36);
  endfunction

  // Offers one word and holds it until the block takes it. The valid stays
  // up after acceptance until the next word, an idle cycle or a drain wait.
  task automatic send_word(logic [31:0] data, logic [2:0] cnt, logic lst);
    while (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= cnt;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_digest(data, cnt, lst);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (digest_queue.size() != 0) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
  endtask

  // Receiver: random back-pressure, or a long hold while rx_hold is set.
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && !rx_hold && !idle_now();
  end

  // Output checker: each digest word against the oldest prediction.
  always @(posedge clk_i) begin
    digest_word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_queue.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("ERROR: unexpected digest word %h idx %0d", m_axis_tdata, m_axis_tuser);
      end else begin
        exp_w = digest_queue.pop_front();
        if (exp_w.idx == 2'd0 && known_part0.size() != 0) begin
          if (known_part0.pop_front() != m_axis_tdata) begin
            errors++;
            if (errors <= MaxReports)
              $display("ERROR: known digest head mismatch got %h", m_axis_tdata);
          end
        end
        if (m_axis_tdata !== exp_w.part || m_axis_tuser !== exp_w.idx ||
            m_axis_tlast !== exp_w.lst) begin
          errors++;
          if (errors <= MaxReports)
            $display("ERROR: digest word exp %h/%0d/%b got %h/%0d/%b", exp_w.part,
                     exp_w.idx, exp_w.lst, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
        if (exp_w.lst) digests_seen++;
      end
    end
  end

  // Watchdog on cycles without any accepted word on either side.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else if (rst_ni)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Long receiver hold-off while the sender keeps offering words.
  initial begin
    wait (words_sent == 40);
    rx_hold = 1'b1;
    repeat (600) @(negedge clk_i);
    rx_hold = 1'b0;
  end

  initial begin
    stim_row_t rows [$];
    int len;
    int room;
    restart_digest();
    for (int i = 0; i < 16; i++) blk_q[i] = '0;
    // Empty message, "abc", extremes of the word and count fields, oversized
    // counts, short words in the middle, and a message of exactly 56 bytes.
    rows.push_back('{32'h0, 3'd0, 1'b1, 1'b1, 64'he3b0c44298fc1c14});
    rows.push_back('{32'h61626300, 3'd3, 1'b1, 1'b1, 64'hba7816bf8f01cfea});
    rows.push_back('{32'hffffffff, 3'd4, 1'b0, 1'b0, 64'h0});
    rows.push_back('{32'hffffffff, 3'd7, 1'b0, 1'b0, 64'h0});
    rows.push_back('{32'h00000000, 3'd5, 1'b0, 1'b0, 64'h0});
    rows.push_back('{32'haa55aa55, 3'd1, 1'b0, 1'b0, 64'h0});
    rows.push_back('{32'h12345678, 3'd2, 1'b0, 1'b0, 64'h0});
    rows.push_back('{32'hdeadbeef, 3'd6, 1'b1, 1'b0, 64'h0});
    for (int i = 0; i < 13; i++)
      rows.push_back('{32'h01020304 * (i + 1), 3'd4, 1'b0, 1'b0, 64'h0});
    rows.push_back('{32'hcafef00d, 3'd4, 1'b0, 1'b0, 64'h0});
    rows.push_back('{32'h0, 3'd0, 1'b1, 1'b0, 64'h0});

    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].known) known_part0.push_back(rows[i].part0);
      send_word(rows[i].data, rows[i].cnt, rows[i].lst);
    end
    wait_drained();

    // Random messages: mostly whole words, the last one often short or empty.
    while (words_sent < rows.size() + RandomWords) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 20);
      room = rows.size() + RandomWords - words_sent - 1;
      if (len > room) len = room;
      idle_free = (words_sent > 100 && words_sent < 125);
      for (int i = 0; i < len; i++)
        send_word($urandom, ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'd4, 1'b0);
      send_word($urandom, 3'($urandom_range(7)), 1'b1);
      if ($urandom_range(4) == 0) wait_drained();
    end
    idle_free = 1'b0;
    wait_drained();
    repeat (200) @(negedge clk_i);

    $display("Run sent %0d words and checked %0d complete digests,", words_sent, digests_seen);
    $display("covering empty, short, multi-block and oversized-count messages.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
